// ===== rtl/core/baq_pkg.sv =====
`timescale 1ns / 1ps

package baq_pkg;

    localparam int InBits    = 16;
    localparam int CodeBits  = 8;
    localparam int AmaxBits  = 16;
    localparam int DivSteps  = 8;
    localparam int CntBits   = 3;
    localparam logic [CntBits-1:0] DivLast = CntBits'(DivSteps - 1);
    localparam logic [CodeBits-1:0] CodeMax = '1;

    typedef enum logic [2:0] {
        S_FILL,
        S_READ,
        S_LOAD,
        S_DIV,
        S_ROUND
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic closes;
        logic div_done;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/block_absmax_quantizer_core.sv =====
`timescale 1ns / 1ps
// sequence: a block closes on the beat that fills it or carries last; its codes then
//   follow one at a time, each through buffer read, load, the 8-step shared restoring
//   divider and round, where round waits while the output beat is held by a stall
// throughput: one sample per cycle while filling; input stalls while a block drains
// reset: synchronous active low, clears fill count, running amax and output valid

module block_absmax_quantizer_core #(
    parameter int BLOCK_LEN   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [baq_pkg::InBits-1:0]    i_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [baq_pkg::CodeBits-1:0]  o_code,
    output logic [baq_pkg::AmaxBits-1:0]  o_block_amax,
    output logic                          o_last_in_block,
    output logic                          o_last_of_input
);

    baq_pkg::t_cmd  w_cmd;
    baq_pkg::t_stat w_stat;

    baq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    baq_datapath #(
        .BLOCK_LEN   (BLOCK_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .i_cmd           (w_cmd),
        .i_out_stall     (i_stall),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_code          (o_code),
        .o_block_amax    (o_block_amax),
        .o_last_in_block (o_last_in_block),
        .o_last_of_input (o_last_of_input)
    );

endmodule

// ===== rtl/core/baq_ctrl.sv =====
`timescale 1ns / 1ps

module baq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  baq_pkg::t_stat i_stat,
    output logic          o_stall,
    output baq_pkg::t_cmd o_cmd
);

    baq_pkg::t_state r_state;
    baq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= baq_pkg::S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            baq_pkg::S_FILL: begin
                if (i_valid && i_stat.closes) n_state = baq_pkg::S_READ;
            end
            baq_pkg::S_READ: begin
                n_state = baq_pkg::S_LOAD;
            end
            baq_pkg::S_LOAD: begin
                n_state = baq_pkg::S_DIV;
            end
            baq_pkg::S_DIV: begin
                if (i_stat.div_done) n_state = baq_pkg::S_ROUND;
            end
            baq_pkg::S_ROUND: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.idx_last ? baq_pkg::S_FILL : baq_pkg::S_READ;
                end
            end
            default: n_state = baq_pkg::S_FILL;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            baq_pkg::S_FILL: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            baq_pkg::S_READ:  o_cmd.rd   = 1'b1;
            baq_pkg::S_LOAD:  o_cmd.load = 1'b1;
            baq_pkg::S_DIV:   o_cmd.step = 1'b1;
            baq_pkg::S_ROUND: o_cmd.emit = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/baq_datapath.sv =====
`timescale 1ns / 1ps

module baq_datapath #(
    parameter int BLOCK_LEN   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [baq_pkg::InBits-1:0]    i_sample,
    input  logic                          i_last,
    input  baq_pkg::t_cmd                 i_cmd,
    input  logic                          i_out_stall,
    output baq_pkg::t_stat                o_stat,
    output logic                          o_valid,
    output logic [baq_pkg::CodeBits-1:0]  o_code,
    output logic [baq_pkg::AmaxBits-1:0]  o_block_amax,
    output logic                          o_last_in_block,
    output logic                          o_last_of_input
);

    localparam int SW = SAMPLE_BITS;
    localparam int IW = $clog2(BLOCK_LEN);
    localparam int DW = SW + 1;
    localparam int NW = SW + 9;
    localparam logic [IW-1:0] LastSlot = IW'(BLOCK_LEN - 1);

    logic [SW-1:0] r_mem [BLOCK_LEN];
    logic [SW-1:0] r_rd;

    logic [IW-1:0] r_fill;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_last_idx;
    logic          r_close_last;
    logic [SW-1:0] r_amax;
    logic [SW-1:0] r_bamax;

    logic [NW-1:0]                   r_rem;
    logic [NW-1:0]                   r_dsh;
    logic [DW-1:0]                   r_den;
    logic [baq_pkg::CodeBits-1:0]    r_q;
    logic [baq_pkg::CntBits-1:0]     r_cnt;

    logic                            r_out_valid;
    logic [baq_pkg::CodeBits-1:0]    r_code;
    logic [baq_pkg::AmaxBits-1:0]    r_out_amax;
    logic                            r_lib;
    logic                            r_loi;

    logic [SW-1:0] w_x;
    logic [SW-1:0] w_mag;
    logic [SW-1:0] w_amax_nx;
    logic [DW-1:0] w_shift;
    logic [NW-1:0] w_num;
    logic          w_ge;
    logic [NW:0]   w_twice;
    logic [NW:0]   w_den_ext;
    logic          w_up;
    logic [baq_pkg::CodeBits:0]   w_code_sum;
    logic [baq_pkg::CodeBits-1:0] w_code;

    // sample, sign taken from bit SAMPLE_BITS-1
    assign w_x       = SW'(i_sample);
    assign w_mag     = w_x[SW-1] ? (~w_x + SW'(1)) : w_x;
    assign w_amax_nx = (w_mag > r_amax) ? w_mag : r_amax;

    // (x + amax) * 255 over 2 * amax
    assign w_shift = {r_rd[SW-1], r_rd} + {1'b0, r_bamax};
    assign w_num   = {w_shift, 8'b0} - NW'(w_shift);
    assign w_ge    = (r_rem >= r_dsh);

    // round half to even
    assign w_twice    = {r_rem, 1'b0};
    assign w_den_ext  = (NW + 1)'(r_den);
    assign w_up       = (w_twice > w_den_ext) || ((w_twice == w_den_ext) && r_q[0]);
    assign w_code_sum = {1'b0, r_q} + (baq_pkg::CodeBits + 1)'(w_up);
    assign w_code     = w_code_sum[baq_pkg::CodeBits] ? baq_pkg::CodeMax
                                                      : w_code_sum[baq_pkg::CodeBits-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_fill] <= w_x;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_amax <= '0;
        end else if (i_cmd.accept) begin
            if (o_stat.closes) begin
                r_fill <= '0;
                r_amax <= '0;
            end else begin
                r_fill <= r_fill + IW'(1);
                r_amax <= w_amax_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.closes) begin
            r_bamax      <= (w_amax_nx == '0) ? SW'(1) : w_amax_nx;
            r_last_idx   <= r_fill;
            r_close_last <= i_last;
            r_idx        <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= w_num;
            r_dsh <= NW'({r_bamax, 1'b0}) << (baq_pkg::DivSteps - 1);
            r_den <= {r_bamax, 1'b0};
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            if (w_ge) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[baq_pkg::CodeBits-2:0], w_ge};
            r_cnt <= r_cnt + baq_pkg::CntBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_code     <= w_code;
            r_out_amax <= baq_pkg::AmaxBits'(r_bamax);
            r_lib      <= o_stat.idx_last;
            r_loi      <= o_stat.idx_last && r_close_last;
        end
    end

    assign o_stat.closes   = (r_fill == LastSlot) || i_last;
    assign o_stat.div_done = (r_cnt == baq_pkg::DivLast);
    assign o_stat.idx_last = (r_idx == r_last_idx);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_valid         = r_out_valid;
    assign o_code          = r_code;
    assign o_block_amax    = r_out_amax;
    assign o_last_in_block = r_lib;
    assign o_last_of_input = r_loi;

endmodule

// ===== rtl/core/baq_checker.sv =====
`timescale 1ns / 1ps

module baq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_stall,
    input logic                          i_out_valid,
    input logic                          i_out_stall,
    input logic [baq_pkg::CodeBits-1:0]  i_code,
    input logic [baq_pkg::AmaxBits-1:0]  i_block_amax,
    input logic                          i_last_in_block,
    input logic                          i_last_of_input
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_code)
            && $stable(i_block_amax) && $stable(i_last_in_block))
        else $error("output beat changed while stalled");

    // input held off while a block is still draining
    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_in_block |-> i_in_stall)
        else $error("input accepted during block drain");

    a_amax_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_block_amax != '0)
        else $error("block amax below floor");

    a_last_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_of_input |-> i_last_in_block)
        else $error("tensor end without block end");

endmodule

bind block_absmax_quantizer_core baq_checker u_baq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_stall      (o_stall),
    .i_out_valid     (o_valid),
    .i_out_stall     (i_stall),
    .i_code          (o_code),
    .i_block_amax    (o_block_amax),
    .i_last_in_block (o_last_in_block),
    .i_last_of_input (o_last_of_input)
);
